### sv/dll_pkg.sv
// shared types and constants for the linked list engine
package dll_pkg;
  localparam int Capacity   = 32;
  localparam int DataWidth  = 32;
  localparam int MaxResults = 32;
  localparam int LinkW      = $clog2(Capacity + 1);
  localparam int IdxW       = $clog2(Capacity);
  localparam logic [LinkW-1:0] NilLink = LinkW'(Capacity);

  typedef enum logic [3:0] {
    CMD_PUSH_HEAD = 4'd0, CMD_PUSH_TAIL = 4'd1, CMD_INSERT_AT = 4'd2,
    CMD_POP_HEAD  = 4'd3, CMD_POP_TAIL  = 4'd4, CMD_REMOVE_AT = 4'd5,
    CMD_CLEAR     = 4'd6, CMD_FORWARD   = 4'd7, CMD_BACKWARD  = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_EMPTY = 2'd1, ST_RANGE = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef logic [LinkW-1:0] link_t;
  typedef logic [DataWidth-1:0] data_t;
endpackage

### sv/dll_free_finder.sv
// iterative lowest free node search over the free mask
module dll_free_finder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [dll_pkg::Capacity-1:0] free_mask,
  output logic               done,
  output dll_pkg::link_t     node
);
  import dll_pkg::*;

  logic        busy_r, busy_nxt;
  link_t       idx_r, idx_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    done_nxt = 1'b0;
    if (go) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (idx_r == NilLink || free_mask[idx_r[IdxW-1:0]]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + LinkW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign done = done_r;
  assign node = idx_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("finder done while busy");
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n) go |=> busy_r)
    else $error("finder did not start");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= NilLink)
    else $error("finder index past end");
endmodule

### sv/doubly_linked_list_engine.sv
// doubly linked list engine top level with sequencer and node store
// channel  | ports                                    | handshake
// request  | in_command in_item_value in_position     | start & !busy
// result   | out_status out_value out_length out_last | out_valid, one cycle, no stall
// timing: error, clear and unknown requests give their result in the cycle after accept;
// an insert searches for the lowest free node, walks the links to its position
// and then links the new node; a remove walks the links and then unlinks the node;
// a traversal reads one node per result and strobes each result in turn.
// reset: synchronous; pool free, list empty. no clearing pass; node store is
// only read at linked nodes. the receiver cannot stall, results are strobed.
module doubly_linked_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic signed [31:0] in_item_value,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_value,
  output logic [5:0]  out_length,
  output logic        out_last
);
  import dll_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FIND  = 10'b0000000010,
    S_WALK  = 10'b0000000100,
    S_RDWT  = 10'b0000001000,
    S_LINK1 = 10'b0000010000,
    S_LINK2 = 10'b0000100000,
    S_UNL1  = 10'b0001000000,
    S_UNL2  = 10'b0010000000,
    S_TRAV  = 10'b0100000000,
    S_TEMIT = 10'b1000000000
  } state_t;

  data_t nval_mem [Capacity];
  link_t next_mem [Capacity];
  link_t prev_mem [Capacity];

  state_t state_r, state_nxt;
  logic [Capacity-1:0] free_r, free_nxt;
  link_t head_r, head_nxt, tail_r, tail_nxt;
  logic [LinkW-1:0] count_r, count_nxt;
  cmd_t  cmd_r, cmd_nxt;
  data_t val_r, val_nxt;
  logic [5:0] pos_r, pos_nxt;
  link_t cur_r, cur_nxt;
  link_t node_r, node_nxt;
  link_t succ_r, succ_nxt;
  logic [5:0] step_r, step_nxt;

  logic ov_r, ov_nxt, ol_r, ol_nxt;
  logic [1:0] os_r, os_nxt;
  data_t odat_r, odat_nxt;

  // single read port, registered
  link_t rd_addr;
  data_t rd_val_r;
  link_t rd_next_r, rd_prev_r;

  // write ports
  logic  wv_en;  link_t wv_addr;
  logic  wn_en;  link_t wn_addr; link_t wn_data;
  logic  wp_en;  link_t wp_addr; link_t wp_data;
  logic  wn2_en; link_t wn2_addr; link_t wn2_data;
  logic  wp2_en; link_t wp2_addr; link_t wp2_data;

  logic find_go, find_done;
  link_t find_node;

  dll_free_finder u_find (
    .clk(clk), .rst_n(rst_n), .go(find_go), .free_mask(free_r),
    .done(find_done), .node(find_node)
  );

  always_ff @(posedge clk) begin
    rd_val_r  <= nval_mem[rd_addr[IdxW-1:0]];
    rd_next_r <= next_mem[rd_addr[IdxW-1:0]];
    rd_prev_r <= prev_mem[rd_addr[IdxW-1:0]];
    if (wv_en) nval_mem[wv_addr[IdxW-1:0]] <= val_r;
    if (wn_en) next_mem[wn_addr[IdxW-1:0]] <= wn_data;
    if (wn2_en) next_mem[wn2_addr[IdxW-1:0]] <= wn2_data;
    if (wp_en) prev_mem[wp_addr[IdxW-1:0]] <= wp_data;
    if (wp2_en) prev_mem[wp2_addr[IdxW-1:0]] <= wp2_data;
  end

  function automatic logic is_node(link_t n);
    return n != NilLink;
  endfunction

  always_comb begin
    state_nxt = state_r; free_nxt = free_r; head_nxt = head_r; tail_nxt = tail_r;
    count_nxt = count_r; cmd_nxt = cmd_r; val_nxt = val_r; pos_nxt = pos_r;
    cur_nxt = cur_r; node_nxt = node_r; succ_nxt = succ_r; step_nxt = step_r;
    ov_nxt = 1'b0; ol_nxt = 1'b1; os_nxt = ST_OK; odat_nxt = '0;
    rd_addr = cur_r;
    wv_en = 1'b0; wv_addr = node_r;
    wn_en = 1'b0; wn_addr = node_r; wn_data = succ_r;
    wp_en = 1'b0; wp_addr = node_r; wp_data = cur_r;
    wn2_en = 1'b0; wn2_addr = cur_r; wn2_data = node_r;
    wp2_en = 1'b0; wp2_addr = succ_r; wp2_data = node_r;
    find_go = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = cmd_t'(in_command);
          val_nxt = data_t'(in_item_value);
          pos_nxt = in_position;
          step_nxt = '0;
          cur_nxt = head_r;
          case (in_command)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT_AT: begin
              if (count_r >= LinkW'(Capacity)) begin
                ov_nxt = 1'b1; os_nxt = ST_FULL;
              end else if (in_command == CMD_INSERT_AT &&
                           LinkW'(in_position) > count_r ||
                           in_command == CMD_INSERT_AT && in_position > 6'(Capacity)) begin
                ov_nxt = 1'b1; os_nxt = ST_RANGE;
              end else begin
                find_go = 1'b1; state_nxt = S_FIND;
              end
            end
            CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE_AT: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1; os_nxt = ST_EMPTY;
              end else if (in_command == CMD_REMOVE_AT &&
                           (in_position > 6'(Capacity) ||
                            LinkW'(in_position) >= count_r)) begin
                ov_nxt = 1'b1; os_nxt = ST_RANGE;
              end else begin
                if (in_command == CMD_POP_HEAD) begin
                  pos_nxt = '0;
                end
                if (in_command == CMD_POP_TAIL) begin
                  cur_nxt = tail_r; pos_nxt = '0;
                end
                state_nxt = S_WALK;
              end
            end
            CMD_CLEAR: begin
              free_nxt = '1; head_nxt = NilLink; tail_nxt = NilLink; count_nxt = '0;
              ov_nxt = 1'b1; os_nxt = ST_OK;
            end
            CMD_FORWARD, CMD_BACKWARD: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1; os_nxt = ST_EMPTY;
              end else begin
                if (in_command == CMD_BACKWARD) cur_nxt = tail_r;
                state_nxt = S_TRAV;
              end
            end
            default: begin
              ov_nxt = 1'b1; os_nxt = ST_OK;
            end
          endcase
        end
      end
      S_FIND: begin
        if (find_done) begin
          node_nxt = find_node;
          if (!is_node(find_node)) begin
            ov_nxt = 1'b1; os_nxt = ST_FULL; state_nxt = S_IDLE;
          end else begin
            free_nxt[find_node[IdxW-1:0]] = 1'b0;
            if (cmd_r == CMD_PUSH_HEAD) pos_nxt = '0;
            if (cmd_r == CMD_PUSH_TAIL) pos_nxt = 6'(count_r);
            // succ: head, or nil when appending
            succ_nxt = head_r;
            if (cmd_r == CMD_PUSH_TAIL || LinkW'(pos_r) >= count_r) succ_nxt = NilLink;
            if (cmd_r == CMD_PUSH_HEAD) succ_nxt = head_r;
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        // inserts walk succ_r forward, removes walk cur_r forward
        if (cmd_r == CMD_PUSH_HEAD || cmd_r == CMD_PUSH_TAIL || cmd_r == CMD_INSERT_AT) begin
          rd_addr = succ_r;
          if (step_r == pos_r || !is_node(succ_r)) begin
            state_nxt = S_RDWT;
          end else begin
            state_nxt = S_RDWT;
          end
        end else begin
          rd_addr = cur_r;
          state_nxt = S_RDWT;
        end
      end
      S_RDWT: begin
        if (cmd_r == CMD_PUSH_HEAD || cmd_r == CMD_PUSH_TAIL || cmd_r == CMD_INSERT_AT) begin
          if (!is_node(succ_r) || step_r == pos_r) begin
            cur_nxt = is_node(succ_r) ? rd_prev_r : tail_r;
            state_nxt = S_LINK1;
          end else begin
            succ_nxt = rd_next_r; step_nxt = step_r + 6'd1; state_nxt = S_WALK;
          end
        end else begin
          if (step_r == pos_r) begin
            node_nxt = cur_r;
            state_nxt = S_UNL1;
          end else begin
            cur_nxt = rd_next_r; step_nxt = step_r + 6'd1; state_nxt = S_WALK;
          end
        end
      end
      S_LINK1: begin
        // cur = pred, succ = successor, node = new
        wv_en = 1'b1;
        wn_en = 1'b1; wp_en = 1'b1;
        if (is_node(cur_r)) wn2_en = 1'b1; else head_nxt = node_r;
        if (is_node(succ_r)) wp2_en = 1'b1; else tail_nxt = node_r;
        count_nxt = count_r + LinkW'(1);
        ov_nxt = 1'b1; os_nxt = ST_OK;
        state_nxt = S_IDLE;
      end
      S_UNL1: begin
        // rd data of node_r is registered now
        cur_nxt = rd_prev_r; succ_nxt = rd_next_r;
        odat_nxt = rd_val_r;
        state_nxt = S_UNL2;
      end
      S_UNL2: begin
        wn2_addr = cur_r; wn2_data = succ_r;
        wp2_addr = succ_r; wp2_data = cur_r;
        if (is_node(cur_r)) wn2_en = 1'b1; else head_nxt = succ_r;
        if (is_node(succ_r)) wp2_en = 1'b1; else tail_nxt = cur_r;
        free_nxt[node_r[IdxW-1:0]] = 1'b1;
        count_nxt = count_r - LinkW'(1);
        ov_nxt = 1'b1; os_nxt = ST_OK; odat_nxt = odat_r;
        state_nxt = S_IDLE;
      end
      S_TRAV: begin
        rd_addr = cur_r;
        state_nxt = S_TEMIT;
      end
      S_TEMIT: begin
        cur_nxt = (cmd_r == CMD_FORWARD) ? rd_next_r : rd_prev_r;
        ov_nxt = 1'b1; os_nxt = ST_OK; odat_nxt = rd_val_r;
        step_nxt = step_r + 6'd1;
        ol_nxt = !is_node(cur_nxt) || (step_r + 6'd1 >= 6'(MaxResults));
        state_nxt = ol_nxt ? S_IDLE : S_TRAV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; free_r <= '1; head_r <= NilLink; tail_r <= NilLink;
      count_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; free_r <= free_nxt; head_r <= head_nxt;
      tail_r <= tail_nxt; count_r <= count_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; val_r <= val_nxt; pos_r <= pos_nxt; cur_r <= cur_nxt;
    node_r <= node_nxt; succ_r <= succ_nxt; step_r <= step_nxt;
    ol_r <= ol_nxt; os_r <= os_nxt; odat_r <= odat_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = ov_r;
  assign out_status = os_r;
  assign out_value  = 32'(signed'(odat_r));
  assign out_length = 6'(count_r);
  assign out_last   = ol_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n) count_r <= LinkW'(Capacity))
    else $error("element count past capacity");
  a_empty_nil: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == NilLink && tail_r == NilLink)
    else $error("empty list with linked head");
  a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ol_r) |-> state_r == S_IDLE)
    else $error("last result while still working");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_FORWARD || in_command == CMD_REMOVE_AT) &&
     count_r != '0 && in_position == 6'd0) |=> busy)
    else $error("walk request did not start");
endmodule

### tb/sv/doubly_linked_list_engine_test.sv
// self-checking testbench for the doubly linked list engine
module doubly_linked_list_engine_test;
  import dll_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] value;
    logic [5:0]  length;
    logic        last;
  } reply_t;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] value;
    logic [5:0]  pos;
    bit          typed;
    logic [1:0]  status;
    logic [5:0]  length;
  } row_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, out_last;
  logic [3:0] in_command = 0;
  logic signed [31:0] in_item_value = 0;
  logic [5:0] in_position = 0;
  logic [1:0] out_status;
  logic signed [31:0] out_value;
  logic [5:0] out_length;

  doubly_linked_list_engine dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_item_value(in_item_value),
    .in_position(in_position), .out_valid(out_valid), .out_status(out_status),
    .out_value(out_value), .out_length(out_length), .out_last(out_last)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // shadow list, index 0 is the head
  logic [31:0] shadow[$];
  reply_t pending[$];
  int errors = 0;
  int idle_pct = 0;
  int quiet = 0;

  task automatic add_reply(logic [1:0] s, logic [31:0] v, bit l);
    reply_t r;
    r.status = s; r.value = v; r.length = 6'(shadow.size()); r.last = l;
    pending.push_back(r);
  endtask

  task automatic predict_list(logic [3:0] cmd, logic [31:0] v, logic [5:0] pos);
    int n;
    logic [31:0] x;
    n = shadow.size();
    case (cmd)
      CMD_PUSH_HEAD, CMD_PUSH_TAIL, CMD_INSERT_AT: begin
        if (n >= Capacity) add_reply(ST_FULL, 0, 1);
        else if (cmd == CMD_INSERT_AT && pos > n) add_reply(ST_RANGE, 0, 1);
        else begin
          if (cmd == CMD_PUSH_HEAD) shadow.push_front(v);
          else if (cmd == CMD_PUSH_TAIL) shadow.push_back(v);
          else shadow.insert(pos, v);
          add_reply(ST_OK, 0, 1);
        end
      end
      CMD_POP_HEAD, CMD_POP_TAIL, CMD_REMOVE_AT: begin
        if (n == 0) add_reply(ST_EMPTY, 0, 1);
        else if (cmd == CMD_REMOVE_AT && pos >= n) add_reply(ST_RANGE, 0, 1);
        else begin
          if (cmd == CMD_POP_HEAD) x = shadow.pop_front();
          else if (cmd == CMD_POP_TAIL) x = shadow.pop_back();
          else begin
            x = shadow[pos];
            shadow.delete(pos);
          end
          add_reply(ST_OK, x, 1);
        end
      end
      CMD_CLEAR: begin
        shadow.delete();
        add_reply(ST_OK, 0, 1);
      end
      CMD_FORWARD, CMD_BACKWARD: begin
        if (n == 0) add_reply(ST_EMPTY, 0, 1);
        else for (int k = 0; k < n && k < MaxResults; k++)
          add_reply(ST_OK, cmd == CMD_FORWARD ? shadow[k] : shadow[n-1-k],
                    k + 1 >= n || k + 1 >= MaxResults);
      end
      default: add_reply(ST_OK, 0, 1);
    endcase
  endtask

  task automatic send(logic [3:0] cmd, logic [31:0] v, logic [5:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_command <= cmd;
    in_item_value <= v;
    in_position <= pos;
    do @(posedge clk); while (busy);
    predict_list(cmd, v, pos);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        $error("result with no request waiting");
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status); errors++;
        end
        if (out_value !== e.value) begin
          $error("out_value expected %0h actual %0h", e.value, out_value); errors++;
        end
        if (out_length !== e.length) begin
          $error("length expected %0d actual %0d", e.length, out_length); errors++;
        end
        if (out_last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("doubly_linked_list_engine: mismatch");
      $finish;
    end
  end

  row_t rows[$];

  task automatic row(logic [3:0] c, logic [31:0] v, logic [5:0] p, bit t,
                     logic [1:0] s, logic [5:0] l);
    row_t r;
    r.cmd = c; r.value = v; r.pos = p; r.typed = t; r.status = s; r.length = l;
    rows.push_back(r);
  endtask

  initial begin
    int phase, op, len, rsel;
    logic [31:0] rv;
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    row(CMD_POP_HEAD, 0, 0, 1, ST_EMPTY, 0);
    row(CMD_POP_TAIL, 0, 0, 1, ST_EMPTY, 0);
    row(CMD_REMOVE_AT, 0, 0, 1, ST_EMPTY, 0);
    row(CMD_FORWARD, 0, 0, 1, ST_EMPTY, 0);
    row(CMD_BACKWARD, 0, 0, 1, ST_EMPTY, 0);
    row(CMD_INSERT_AT, 5, 1, 1, ST_RANGE, 0);
    row(CMD_PUSH_HEAD, 32'h8000_0000, 0, 0, 0, 0);
    row(CMD_PUSH_TAIL, 32'h7fff_ffff, 0, 0, 0, 0);
    row(CMD_INSERT_AT, 32'hffff_ffff, 0, 0, 0, 0);
    row(CMD_INSERT_AT, 32'h0, 3, 0, 0, 0);
    row(CMD_INSERT_AT, 32'h1234_5678, 2, 0, 0, 0);
    row(CMD_INSERT_AT, 1, 63, 1, ST_RANGE, 5);
    row(CMD_FORWARD, 0, 0, 0, 0, 0);
    row(CMD_BACKWARD, 0, 0, 0, 0, 0);
    row(CMD_REMOVE_AT, 0, 5, 1, ST_RANGE, 5);
    row(CMD_REMOVE_AT, 0, 2, 0, 0, 0);
    row(CMD_POP_HEAD, 0, 0, 0, 0, 0);
    row(CMD_POP_TAIL, 0, 0, 0, 0, 0);
    row(4'd9, 32'hffff_ffff, 6'h3f, 0, 0, 0);
    row(4'd15, 0, 0, 0, 0, 0);
    row(CMD_CLEAR, 0, 0, 1, ST_OK, 0);
    row(CMD_FORWARD, 0, 0, 1, ST_EMPTY, 0);

    foreach (rows[i]) begin
      if (rows[i].typed) begin
        send(rows[i].cmd, rows[i].value, rows[i].pos);
        pending[pending.size()-1].status = rows[i].status;
        pending[pending.size()-1].length = rows[i].length;
      end else send(rows[i].cmd, rows[i].value, rows[i].pos);
    end
    drain();

    // fill the pool to the limit, then overflow head pushes and inserts, traverse and remove
    for (int i = 0; i < Capacity; i++) send(CMD_PUSH_TAIL, $urandom, 0);
    send(CMD_PUSH_HEAD, 1, 0);
    send(CMD_INSERT_AT, 2, 0);
    send(CMD_INSERT_AT, 2, 40);
    send(CMD_FORWARD, 0, 0);
    send(CMD_BACKWARD, 0, 0);
    send(CMD_REMOVE_AT, 0, 31);
    send(CMD_REMOVE_AT, 0, 0);
    drain();

    for (phase = 0; phase < 4; phase++) begin
      idle_pct = phase == 1 ? 57 : (phase == 3 ? 26 : 0);
      for (int i = 0; i < 40; i++) begin
        len = shadow.size();
        op = $urandom_range(99);
        rsel = $urandom_range(3);
        rv = rsel == 0 ? 32'h8000_0000 : (rsel == 1 ? 32'h7fff_ffff : $urandom);
        if (op < 40) send(4'($urandom_range(2)), rv, 6'($urandom_range(len)));
        else if (op < 70) send(4'($urandom_range(3, 5)), 0,
                               6'($urandom_range(len == 0 ? 0 : len - 1)));
        else if (op < 82) send(4'($urandom_range(7, 8)), 0, 0);
        else if (op < 85) send(CMD_CLEAR, 0, 0);
        else send(4'($urandom), $urandom, 6'($urandom));
      end
      drain();
    end

    if (errors == 0 && pending.size() == 0) $display("doubly_linked_list_engine: match");
    else $display("doubly_linked_list_engine: mismatch");
    $finish;
  end
endmodule
